// ----- design/fpts_pkg.sv -----
// Shared types and constants for the fixed-priority tick scheduler.
package fpts_pkg;

	localparam int SLOT_COUNT  = 8;
	localparam int SLOT_W      = 40;
	localparam int CFG_IDX_W   = 3;
	localparam int TASK_IDX_W  = 3;
	localparam int PRIO_W      = 8;
	localparam int WORK_W      = 16;
	localparam int RESP_W      = 16;
	localparam int TICK_W      = 32;

	localparam int NUM_TASKS_DEF = 8;
	localparam int TIME_BITS_DEF = 16;

	// Field positions inside one task slot register
	localparam int WCET_LSB   = 0;
	localparam int PERIOD_LSB = 16;
	localparam int PRIO_LSB   = 32;

	// Best candidate so far, handed from cell to cell
	typedef struct packed {
		logic                  valid;
		logic [PRIO_W-1:0]     prio;
		logic [TASK_IDX_W-1:0] idx;
	} token_t;

	// Broadcast control from the sequencer to every cell
	typedef struct packed {
		logic                  release_en;
		logic                  restart;
		logic                  scan;
		logic                  commit;
		logic                  pick_valid;
		logic [TASK_IDX_W-1:0] pick_idx;
	} cell_ctrl_t;

	// Per-cell report, zero unless the cell ran in the committed tick
	typedef struct packed {
		logic              done;
		logic [RESP_W-1:0] resp;
		logic [RESP_W-1:0] worst;
	} cell_res_t;

endpackage

// ----- design/fpts_cell.sv -----
// One task cell: slot config, release countdown, work, age, worst case and scan compare.
module fpts_cell #(
	parameter int TIME_BITS = fpts_pkg::TIME_BITS_DEF,
	parameter int CELL_IDX  = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          slot_we,
	input  logic [fpts_pkg::SLOT_W-1:0]   slot_data,
	input  fpts_pkg::cell_ctrl_t          ctrl,
	input  fpts_pkg::token_t              tok_in,
	output fpts_pkg::token_t              tok_out,
	output fpts_pkg::cell_res_t           res
);

	localparam logic [fpts_pkg::TASK_IDX_W-1:0] MY_IDX = fpts_pkg::TASK_IDX_W'(CELL_IDX);

	logic [fpts_pkg::SLOT_W-1:0] slot_q;
	logic [fpts_pkg::WORK_W-1:0] cd_q;
	logic [fpts_pkg::WORK_W-1:0] work_q;
	logic [TIME_BITS-1:0]        age_q;
	logic [fpts_pkg::RESP_W-1:0] worst_q;
	fpts_pkg::token_t            tok_q;

	logic [fpts_pkg::WORK_W-1:0] wcet;
	logic [fpts_pkg::WORK_W-1:0] period;
	logic [fpts_pkg::PRIO_W-1:0] prio;
	logic                        used;

	logic [fpts_pkg::WORK_W-1:0] cd_cur;
	logic [fpts_pkg::WORK_W-1:0] work_cur;
	logic [TIME_BITS-1:0]        age_cur;
	logic                        eligible;
	logic                        selected;
	logic [fpts_pkg::WORK_W-1:0] work_dec;
	logic                        done;
	logic [32:0]                 age_ext;
	logic [fpts_pkg::RESP_W-1:0] resp;
	logic [fpts_pkg::RESP_W-1:0] worst_new;

	assign wcet   = slot_q[fpts_pkg::WCET_LSB   +: fpts_pkg::WORK_W];
	assign period = slot_q[fpts_pkg::PERIOD_LSB +: fpts_pkg::WORK_W];
	assign prio   = slot_q[fpts_pkg::PRIO_LSB   +: fpts_pkg::PRIO_W];
	assign used   = (period != '0);

	// Restart sees cleared run state before the release step
	assign cd_cur   = ctrl.restart ? '0 : cd_q;
	assign work_cur = ctrl.restart ? '0 : work_q;
	assign age_cur  = ctrl.restart ? '0 : age_q;

	// Compare against the upstream best; strictly greater keeps the lower index on ties
	assign eligible = used && (work_q != '0);

	// Run step for the picked task
	assign selected  = ctrl.pick_valid && (ctrl.pick_idx == MY_IDX);
	assign work_dec  = work_q - fpts_pkg::WORK_W'(1);
	assign done      = (work_dec == '0);
	assign age_ext   = 33'(age_q) + 33'd1;
	assign resp      = (age_ext > 33'd65535) ? '1 : age_ext[fpts_pkg::RESP_W-1:0];
	assign worst_new = (done && (resp > worst_q)) ? resp : worst_q;

	always_comb begin
		res = '0;
		if (selected) begin
			res.done  = done;
			res.resp  = done ? resp : '0;
			res.worst = worst_new;
		end
	end

	assign tok_out = tok_q;

	// Slot register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (slot_we) begin
			slot_q <= slot_data;
		end
	end

	// Task run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_q    <= '0;
			work_q  <= '0;
			age_q   <= '0;
			worst_q <= '0;
		end else if (ctrl.release_en) begin
			if (ctrl.restart) begin
				worst_q <= '0;
			end
			if (!used) begin
				cd_q   <= cd_cur;
				work_q <= work_cur;
				age_q  <= age_cur;
			end else if (cd_cur == '0) begin
				cd_q   <= period - fpts_pkg::WORK_W'(1);
				work_q <= wcet;
				age_q  <= '0;
			end else begin
				cd_q   <= cd_cur - fpts_pkg::WORK_W'(1);
				work_q <= work_cur;
				age_q  <= age_cur;
			end
		end else if (ctrl.commit) begin
			if (selected) begin
				work_q  <= work_dec;
				worst_q <= worst_new;
			end
			if (age_q != '1) begin
				age_q <= age_q + TIME_BITS'(1);
			end
		end
	end

	// Scan token stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (ctrl.scan) begin
			if (eligible && (!tok_in.valid || (prio > tok_in.prio))) begin
				tok_q.valid <= 1'b1;
				tok_q.prio  <= prio;
				tok_q.idx   <= MY_IDX;
			end else begin
				tok_q <= tok_in;
			end
		end
	end

endmodule

// ----- design/fixed_priority_tick_scheduler.sv -----
// A tick beat accepted in idle passes the release step and the scan of the task cell chain,
// and its result beat is registered on commit; the next tick is accepted only after that
// commit. The selection token walks the task cell chain one cell per cycle during the scan.
// A waiting result does not block the next tick until its commit cycle.
// Reset (arst_n low) clears all slots, time, countdowns, work, ages and worst cases at once.
// Top level: sequencer, config decode, task cell chain and result register.
module fixed_priority_tick_scheduler #(
	parameter int NUM_TASKS = fpts_pkg::NUM_TASKS_DEF,
	parameter int TIME_BITS = fpts_pkg::TIME_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fpts_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fpts_pkg::SLOT_W-1:0]      cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             restart,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [fpts_pkg::TICK_W-1:0]      tick_index,
	output logic                             busy_res,
	output logic [fpts_pkg::TASK_IDX_W-1:0]  running_task,
	output logic                             job_done,
	output logic [fpts_pkg::RESP_W-1:0]      job_response,
	output logic [fpts_pkg::RESP_W-1:0]      worst_response
);

	localparam int CNT_W = $clog2(NUM_TASKS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REL,
		ST_SCAN,
		ST_EXEC
	} state_t;

	state_t                      state_q;
	logic                        restart_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [fpts_pkg::TICK_W-1:0] time_q;

	fpts_pkg::cell_ctrl_t        ctrl;
	fpts_pkg::token_t            tok [NUM_TASKS+1];
	fpts_pkg::cell_res_t         cres [NUM_TASKS];
	fpts_pkg::cell_res_t         sel_res;
	fpts_pkg::token_t            pick;
	logic                        commit;

	assign in_ready = (state_q == ST_IDLE);
	assign pick     = tok[NUM_TASKS];
	assign commit   = (state_q == ST_EXEC) && (!out_valid || out_ready);

	always_comb begin
		ctrl            = '0;
		ctrl.release_en = (state_q == ST_REL);
		ctrl.restart    = restart_q;
		ctrl.scan       = (state_q == ST_SCAN);
		ctrl.commit     = commit;
		ctrl.pick_valid = commit && pick.valid;
		ctrl.pick_idx   = pick.idx;
	end

	assign tok[0] = '0;

	// Task cell chain
	for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
		fpts_cell #(
			.TIME_BITS (TIME_BITS),
			.CELL_IDX  (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.slot_we   (cfg_we && (cfg_index == fpts_pkg::CFG_IDX_W'(i))),
			.slot_data (cfg_data),
			.ctrl      (ctrl),
			.tok_in    (tok[i]),
			.tok_out   (tok[i+1]),
			.res       (cres[i])
		);
	end

	// Only the cell that ran reports nonzero
	always_comb begin
		sel_res = '0;
		for (int i = 0; i < NUM_TASKS; i++) begin
			sel_res = sel_res | cres[i];
		end
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			restart_q      <= 1'b0;
			cnt_q          <= '0;
			time_q         <= '0;
			out_valid      <= 1'b0;
			tick_index     <= '0;
			busy_res       <= 1'b0;
			running_task   <= '0;
			job_done       <= 1'b0;
			job_response   <= '0;
			worst_response <= '0;
		end else begin
			// Result beat is loaded on commit and freed when taken
			if (commit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						restart_q <= restart;
						state_q   <= ST_REL;
					end
				end
				ST_REL: begin
					if (restart_q) begin
						time_q <= '0;
					end
					cnt_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (cnt_q == CNT_W'(NUM_TASKS - 1)) begin
						state_q <= ST_EXEC;
					end
					cnt_q <= cnt_q + CNT_W'(1);
				end
				ST_EXEC: begin
					if (commit) begin
						tick_index     <= time_q;
						busy_res       <= pick.valid;
						running_task   <= pick.valid ? pick.idx : '0;
						job_done       <= sel_res.done;
						job_response   <= sel_res.resp;
						worst_response <= sel_res.worst;
						time_q         <= time_q + fpts_pkg::TICK_W'(1);
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- design/fpts_checker.sv -----
// Port-level checks for the tick scheduler, bound to the top level.
module fpts_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [fpts_pkg::TICK_W-1:0]      tick_index,
	input logic                             busy_res,
	input logic [fpts_pkg::TASK_IDX_W-1:0]  running_task,
	input logic                             job_done,
	input logic [fpts_pkg::RESP_W-1:0]      job_response,
	input logic [fpts_pkg::RESP_W-1:0]      worst_response
);

	// A stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tick_index) && $stable(running_task)
			&& $stable(worst_response))
		else $error("result beat changed while stalled");

	// Idle tick reports nothing
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> running_task == '0 && !job_done && worst_response == '0)
		else $error("idle tick carries task data");

	// A finished job has a nonzero response bounded by the worst case
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && job_done |-> busy_res && job_response != '0
			&& worst_response >= job_response)
		else $error("finished job report inconsistent");

	// No response without a finished job
	a_resp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !job_done |-> job_response == '0)
		else $error("response time without job completion");

endmodule

bind fixed_priority_tick_scheduler fpts_checker u_fpts_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.tick_index     (tick_index),
	.busy_res       (busy_res),
	.running_task   (running_task),
	.job_done       (job_done),
	.job_response   (job_response),
	.worst_response (worst_response)
);

// ----- tb/fixed_priority_tick_scheduler_tb.sv -----
// Self-checking testbench for the fixed-priority tick scheduler.
module fixed_priority_tick_scheduler_tb;

	localparam int NUM_TASKS      = fpts_pkg::NUM_TASKS_DEF;
	localparam int TIME_BITS      = fpts_pkg::TIME_BITS_DEF;
	localparam int ACTIVE_SLOTS   = (NUM_TASKS > fpts_pkg::SLOT_COUNT) ?
		fpts_pkg::SLOT_COUNT : NUM_TASKS;
	localparam logic [31:0] AGE_MAX = 32'((64'd1 << TIME_BITS) - 64'd1);
	localparam int LATENCY        = NUM_TASKS + 3;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RAND_PHASES    = 10;
	localparam int RAND_TICKS     = 165;
	localparam int SAT_TICKS      = 300;

	// Configuration register map: one register per task slot
	typedef enum logic [fpts_pkg::CFG_IDX_W-1:0] {
		SLOT_REG_0, SLOT_REG_1, SLOT_REG_2, SLOT_REG_3,
		SLOT_REG_4, SLOT_REG_5, SLOT_REG_6, SLOT_REG_7
	} slot_reg_e;

	typedef enum logic [1:0] {PH_EMPTY, PH_MIXED, PH_EXTREME} dir_phase_e;

	// One result beat
	typedef struct packed {
		logic [fpts_pkg::TICK_W-1:0]     tick;
		logic                            busy;
		logic [fpts_pkg::TASK_IDX_W-1:0] run_idx;
		logic                            done;
		logic [fpts_pkg::RESP_W-1:0]     resp;
		logic [fpts_pkg::RESP_W-1:0]     worst;
	} tick_res_t;

	// Directed stimulus row; want is used only where typed is set
	typedef struct packed {
		dir_phase_e phase;
		logic       restart_req;
		logic       typed;
		tick_res_t  want;
	} dir_row_t;

	localparam tick_res_t NO_WANT  = '0;
	localparam tick_res_t IDLE_AT0 = '{32'd0, 1'b0, 3'd0, 1'b0, 16'd0, 16'd0};
	localparam tick_res_t IDLE_AT1 = '{32'd1, 1'b0, 3'd0, 1'b0, 16'd0, 16'd0};

	localparam int DIR_COUNT = 21;
	localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
		// nothing configured: idle ticks, restart rewinds time
		'{PH_EMPTY,   1'b0, 1'b1, IDLE_AT0},
		'{PH_EMPTY,   1'b0, 1'b1, IDLE_AT1},
		'{PH_EMPTY,   1'b1, 1'b1, IDLE_AT0},
		// mixed set: ties, unused slot, zero wcet, restart mid-run
		'{PH_MIXED,   1'b0, 1'b0, NO_WANT},
		'{PH_MIXED,   1'b0, 1'b0, NO_WANT},
		'{PH_MIXED,   1'b0, 1'b0, NO_WANT},
		'{PH_MIXED,   1'b0, 1'b0, NO_WANT},
		'{PH_MIXED,   1'b0, 1'b0, NO_WANT},
		'{PH_MIXED,   1'b0, 1'b0, NO_WANT},
		'{PH_MIXED,   1'b0, 1'b0, NO_WANT},
		'{PH_MIXED,   1'b1, 1'b0, NO_WANT},
		'{PH_MIXED,   1'b0, 1'b0, NO_WANT},
		'{PH_MIXED,   1'b0, 1'b0, NO_WANT},
		'{PH_MIXED,   1'b0, 1'b0, NO_WANT},
		'{PH_MIXED,   1'b0, 1'b0, NO_WANT},
		// field extremes; slot left with work is switched off
		'{PH_EXTREME, 1'b0, 1'b0, NO_WANT},
		'{PH_EXTREME, 1'b0, 1'b0, NO_WANT},
		'{PH_EXTREME, 1'b0, 1'b0, NO_WANT},
		'{PH_EXTREME, 1'b1, 1'b0, NO_WANT},
		'{PH_EXTREME, 1'b0, 1'b0, NO_WANT},
		'{PH_EXTREME, 1'b0, 1'b0, NO_WANT}
	};

	logic                            clk            = 1'b0;
	logic                            arst_n         = 1'b0;
	logic                            cfg_we         = 1'b0;
	logic [fpts_pkg::CFG_IDX_W-1:0]  cfg_index      = '0;
	logic [fpts_pkg::SLOT_W-1:0]     cfg_data       = '0;
	logic                            in_valid       = 1'b0;
	logic                            in_ready;
	logic                            restart        = 1'b0;
	logic                            out_valid;
	logic                            out_ready      = 1'b0;
	logic [fpts_pkg::TICK_W-1:0]     tick_index;
	logic                            busy_res;
	logic [fpts_pkg::TASK_IDX_W-1:0] running_task;
	logic                            job_done;
	logic [fpts_pkg::RESP_W-1:0]     job_response;
	logic [fpts_pkg::RESP_W-1:0]     worst_response;

	// Scheduler shadow state
	logic [fpts_pkg::SLOT_W-1:0] slot_cfg   [fpts_pkg::SLOT_COUNT];
	logic [fpts_pkg::TICK_W-1:0] now_tick;
	logic [15:0]                 countdown  [fpts_pkg::SLOT_COUNT];
	logic [15:0]                 work       [fpts_pkg::SLOT_COUNT];
	logic [31:0]                 age        [fpts_pkg::SLOT_COUNT];
	logic [15:0]                 worst      [fpts_pkg::SLOT_COUNT];

	tick_res_t pending_ticks[$];
	int        mismatches   = 0;
	int        stuck_cycles = 0;
	int        ready_hold   = 0;
	bit        quiet        = 1'b0;

	fixed_priority_tick_scheduler #(
		.NUM_TASKS(NUM_TASKS),
		.TIME_BITS(TIME_BITS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.restart       (restart),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.tick_index    (tick_index),
		.busy_res      (busy_res),
		.running_task  (running_task),
		.job_done      (job_done),
		.job_response  (job_response),
		.worst_response(worst_response)
	);

	always #5 clk = ~clk;

	function automatic int draw_gap();
		return quiet ? 0 : $urandom_range(0, 8);
	endfunction

	function automatic logic [fpts_pkg::SLOT_W-1:0] pack_slot(input logic [15:0] wcet,
			input logic [15:0] period, input logic [7:0] prio);
		return {prio, period, wcet};
	endfunction

	// Time and all per-task run state back to zero; slots untouched
	function automatic void clear_run();
		now_tick = '0;
		for (int i = 0; i < fpts_pkg::SLOT_COUNT; i++) begin
			countdown[i] = '0;
			work[i]      = '0;
			age[i]       = '0;
			worst[i]     = '0;
		end
	endfunction

	// One scheduler tick: release, pick, run, age
	function automatic tick_res_t schedule_tick(input logic restart_req);
		tick_res_t   r;
		int          pick;
		logic [7:0]  best;
		logic [7:0]  prio;
		logic [15:0] wcet;
		logic [15:0] period;
		logic [15:0] resp;
		r    = '0;
		pick = -1;
		best = '0;
		if (restart_req)
			clear_run();
		r.tick = now_tick;
		for (int i = 0; i < ACTIVE_SLOTS; i++) begin
			wcet   = slot_cfg[i][fpts_pkg::WCET_LSB +: 16];
			period = slot_cfg[i][fpts_pkg::PERIOD_LSB +: 16];
			prio   = slot_cfg[i][fpts_pkg::PRIO_LSB +: fpts_pkg::PRIO_W];
			if (period != 16'd0) begin
				if (countdown[i] == 16'd0) begin
					work[i]      = wcet;
					age[i]       = '0;
					countdown[i] = period - 16'd1;
				end else begin
					countdown[i] = countdown[i] - 16'd1;
				end
				// strict compare keeps the lowest index on a tie
				if (work[i] != 16'd0 && (pick < 0 || prio > best)) begin
					pick = i;
					best = prio;
				end
			end
		end
		if (pick >= 0) begin
			work[pick] = work[pick] - 16'd1;
			r.busy     = 1'b1;
			r.run_idx  = fpts_pkg::TASK_IDX_W'(pick);
			if (work[pick] == 16'd0) begin
				resp   = (age[pick] >= 32'd65535) ? 16'hFFFF : 16'(age[pick] + 32'd1);
				r.done = 1'b1;
				r.resp = resp;
				if (resp > worst[pick])
					worst[pick] = resp;
			end
			r.worst = worst[pick];
		end
		// ages saturate; unused slots keep aging too
		for (int i = 0; i < fpts_pkg::SLOT_COUNT; i++)
			if (age[i] < AGE_MAX)
				age[i] = age[i] + 32'd1;
		now_tick = now_tick + 32'd1;
		return r;
	endfunction

	// Write one slot register; cfg_we stays high for back-to-back writes
	task automatic write_slot(input slot_reg_e idx, input logic [fpts_pkg::SLOT_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		slot_cfg[idx] = value;
	endtask

	// Mostly small values so jobs finish; now and then a raw 40-bit word
	function automatic logic [fpts_pkg::SLOT_W-1:0] random_slot();
		logic [fpts_pkg::SLOT_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = {8'($urandom), 32'($urandom)};
			1: v = pack_slot(16'($urandom_range(0, 6)), 16'd0, 8'($urandom));
			2: v = pack_slot(16'($urandom_range(0, 40)), 16'($urandom_range(1, 200)),
					8'($urandom));
			default: v = pack_slot(16'($urandom_range(0, 5)), 16'($urandom_range(1, 16)),
					8'($urandom_range(0, 3)));
		endcase
		return v;
	endfunction

	task automatic load_phase(input dir_phase_e ph);
		case (ph)
			PH_MIXED: begin
				write_slot(SLOT_REG_0, pack_slot(16'd3, 16'd5, 8'd2));
				write_slot(SLOT_REG_1, pack_slot(16'd1, 16'd2, 8'd7));
				write_slot(SLOT_REG_2, pack_slot(16'd5, 16'd0, 8'd255));
				write_slot(SLOT_REG_3, pack_slot(16'd0, 16'd1, 8'd200));
				write_slot(SLOT_REG_4, pack_slot(16'd2, 16'd4, 8'd7));
				write_slot(SLOT_REG_5, pack_slot(16'd1, 16'd1, 8'd0));
				write_slot(SLOT_REG_6, pack_slot(16'd4, 16'd7, 8'd3));
				write_slot(SLOT_REG_7, pack_slot(16'd1, 16'd3, 8'd7));
			end
			PH_EXTREME: begin
				write_slot(SLOT_REG_0, pack_slot(16'd1, 16'd1, 8'd0));
				write_slot(SLOT_REG_1, pack_slot(16'hFFFF, 16'hFFFF, 8'hFF));
				write_slot(SLOT_REG_2, pack_slot(16'hFFFF, 16'd0, 8'hFF));
				write_slot(SLOT_REG_3, pack_slot(16'd0, 16'hFFFF, 8'hFF));
				write_slot(SLOT_REG_4, pack_slot(16'd1, 16'hFFFF, 8'h80));
				write_slot(SLOT_REG_5, '0);
				write_slot(SLOT_REG_6, pack_slot(16'd1, 16'd0, 8'hFF));
				write_slot(SLOT_REG_7, pack_slot(16'hFFFF, 16'd1, 8'hFF));
			end
			default: ;
		endcase
		cfg_we <= 1'b0;
	endtask

	// Drive one tick beat and record what it should produce
	task automatic send_tick(input logic restart_req, input logic typed, input tick_res_t want);
		tick_res_t predicted;
		int        gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		restart  <= restart_req;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = schedule_tick(restart_req);
		pending_ticks = {pending_ticks, (typed ? want : predicted)};
	endtask

	// Stop sending, let every expected beat arrive, then let the block settle
	task automatic finish_batch();
		in_valid <= 1'b0;
		while (pending_ticks.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic check_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, fname, want, got);
			mismatches++;
		end
	endtask

	// Result side: random back-pressure, compare each beat with the oldest prediction
	always @(posedge clk) begin : result_side
		tick_res_t want;
		int        s;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_ticks.size() == 0) begin
					$display("%0t: unexpected result beat, tick_index %0d", $time, tick_index);
					mismatches++;
				end else begin
					want = pending_ticks.pop_front();
					check_field("tick_index", want.tick, tick_index);
					check_field("busy_res", 32'(want.busy), 32'(busy_res));
					check_field("running_task", 32'(want.run_idx), 32'(running_task));
					check_field("job_done", 32'(want.done), 32'(job_done));
					check_field("job_response", 32'(want.resp), 32'(job_response));
					check_field("worst_response", 32'(want.worst), 32'(worst_response));
				end
				s = draw_gap();
				out_ready  <= (s == 0);
				ready_hold <= s;
			end else if (ready_hold > 0) begin
				ready_hold <= ready_hold - 1;
				if (ready_hold == 1)
					out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: too long without any beat or register write
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin : stimulus
		dir_phase_e cur_phase;
		for (int i = 0; i < fpts_pkg::SLOT_COUNT; i++)
			slot_cfg[i] = '0;
		clear_run();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		cur_phase = PH_EMPTY;
		for (int r = 0; r < DIR_COUNT; r++) begin
			if (DIR_ROWS[r].phase != cur_phase) begin
				finish_batch();
				cur_phase = DIR_ROWS[r].phase;
				load_phase(cur_phase);
			end
			send_tick(DIR_ROWS[r].restart_req, DIR_ROWS[r].typed, DIR_ROWS[r].want);
		end
		finish_batch();

		// Long starvation: park a waiting job's slot while it ages, then let it run
		quiet = 1'b1;
		write_slot(SLOT_REG_0, pack_slot(16'd1, 16'hFFFF, 8'd0));
		write_slot(SLOT_REG_1, pack_slot(16'd2, 16'd1, 8'd1));
		for (int i = 2; i < fpts_pkg::SLOT_COUNT; i++)
			write_slot(slot_reg_e'(i), '0);
		cfg_we <= 1'b0;
		send_tick(1'b1, 1'b0, NO_WANT);
		repeat (9) send_tick(1'b0, 1'b0, NO_WANT);
		finish_batch();
		write_slot(SLOT_REG_0, pack_slot(16'd1, 16'd0, 8'd0));
		cfg_we <= 1'b0;
		repeat (SAT_TICKS) send_tick(1'b0, 1'b0, NO_WANT);
		finish_batch();
		write_slot(SLOT_REG_0, pack_slot(16'd1, 16'hFFFF, 8'd0));
		write_slot(SLOT_REG_1, pack_slot(16'd2, 16'd0, 8'd1));
		cfg_we <= 1'b0;
		repeat (3) send_tick(1'b0, 1'b0, NO_WANT);
		finish_batch();

		// Random task sets, occasional restarts, some phases without idling
		for (int p = 0; p < RAND_PHASES; p++) begin
			quiet = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < fpts_pkg::SLOT_COUNT; i++)
				write_slot(slot_reg_e'(i), random_slot());
			cfg_we <= 1'b0;
			for (int n = 0; n < RAND_TICKS; n++)
				send_tick(($urandom_range(0, 39) == 0), 1'b0, NO_WANT);
			finish_batch();
		end

		repeat (LATENCY) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
